@@ rtl/msre_pkg.sv @@
// Package with the types and constants shared by the record extractor modules.
package msre_pkg;

  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 32;

  localparam logic [CfgIdxW-1:0] CFG_MARKER_WORD = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_RECORD_LIMIT = 2'd1;

  localparam logic [31:0] MARKER_RESET = 32'h464F_524D;
  localparam logic [7:0] LIMIT_RESET = 8'd5;

  typedef enum logic [1:0] {
    PH_SEARCH,
    PH_LENGTH,
    PH_PAYLOAD
  } phase_e;

  typedef struct packed {
    logic       valid;
    logic       burst;
    logic [7:0] data;
    logic [7:0] num;
    logic       last;
  } res_t;

  typedef struct packed {
    phase_e     phase;
    logic [1:0] len_seen;
    logic       payload_zero;
  } stat_t;

endpackage

@@ rtl/marker_sized_record_extractor_unit.sv @@
// Top level of the marker sized record extractor with input register and configuration.
//
// The input channel (in_valid_i, in_stall_o, data_byte_i) moves one stream byte per
// transaction. The output channel (out_valid_o, out_stall_i, out_byte_o,
// record_number_o, record_end_o) moves one extracted byte per transaction.
// Configuration is written through cfg_we_i, cfg_index_i and cfg_data_i; the user
// is to write it only while the block is idle, as the block itself does not enforce
// this. Index 0 is the marker word, index 1 the record limit. An accepted byte is
// held in the input register and is parsed into the result register once the output
// stage is free; the result register then offers it. Throughput is one byte per
// cycle while the receiver does not stall; a marker match produces four output
// transactions, which holds the input register while the result register plays out
// the remaining marker bytes. Bytes that are dropped produce nothing.
// When the receiver stalls, the result register holds and the input register fills;
// in_stall_o then rises and the sender holds its transaction.
// Reset clears the parser state, the record count and both valid flags, and loads
// the marker word with ASCII FORM and the record limit with five.
module marker_sized_record_extractor_unit import msre_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [7:0]          data_byte_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [7:0]          out_byte_o,
  output logic [7:0]          record_number_o,
  output logic                record_end_o
);

  logic [31:0] marker_q;
  logic [7:0]  limit_q;
  logic        in_valid_q, in_valid_d;
  logic [7:0]  in_byte_q;
  logic        in_take;
  logic        step;
  logic        out_free;
  logic        burst_busy;
  res_t        res;
  stat_t       stat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      marker_q <= MARKER_RESET;
      limit_q  <= LIMIT_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_MARKER_WORD:  marker_q <= cfg_data_i;
        CFG_RECORD_LIMIT: limit_q  <= cfg_data_i[7:0];
        default: begin
        end
      endcase
    end
  end

  assign step       = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !step;
  assign in_take    = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_take) begin
      in_valid_d = 1'b1;
    end else if (step) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_byte_q <= data_byte_i;
    end
  end

  msre_parser u_parser (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (step),
    .byte_i         (in_byte_q),
    .marker_word_i  (marker_q),
    .record_limit_i (limit_q),
    .res_o          (res),
    .stat_o         (stat)
  );

  msre_out_stage u_out (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .load_i          (step && res.valid),
    .res_i           (res),
    .marker_word_i   (marker_q),
    .out_stall_i     (out_stall_i),
    .free_o          (out_free),
    .burst_busy_o    (burst_busy),
    .out_valid_o     (out_valid_o),
    .out_byte_o      (out_byte_o),
    .record_number_o (record_number_o),
    .record_end_o    (record_end_o)
  );

  a_burst_has_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    burst_busy |-> out_valid_o)
    else $error("Marker bytes pending without a valid result.");

  a_stall_needs_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_valid_q)
    else $error("Input stalled with an empty input register.");

  a_search_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stat.phase == PH_SEARCH) |-> (stat.len_seen == 2'd0 && stat.payload_zero))
    else $error("Length or payload count left over while searching.");

  a_burst_from_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && res.burst) |=> (stat.phase == PH_LENGTH && burst_busy))
    else $error("A marker match did not enter the length phase.");

endmodule

@@ rtl/msre_parser.sv @@
// Record parser state machine: marker search, length capture and payload count.
module msre_parser import msre_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        step_i,
  input  logic [7:0]  byte_i,
  input  logic [31:0] marker_word_i,
  input  logic [7:0]  record_limit_i,
  output res_t        res_o,
  output stat_t       stat_o
);

  phase_e      phase_q, phase_d;
  logic [23:0] window_q, window_d;
  logic [1:0]  fill_q, fill_d;
  logic [1:0]  len_seen_q, len_seen_d;
  logic [31:0] len_acc_q, len_acc_d;
  logic [31:0] left_q, left_d;
  logic [7:0]  done_q, done_d;

  logic [31:0] acc_next;
  logic [31:0] left_next;
  logic [31:0] win_word;
  logic        hit;
  logic        finish;

  assign acc_next  = {len_acc_q[23:0], byte_i};
  assign left_next = left_q - 32'd1;
  assign win_word  = {window_q, byte_i};
  assign hit       = (fill_q == 2'd3) && (win_word == marker_word_i);

  always_comb begin
    phase_d    = phase_q;
    window_d   = window_q;
    fill_d     = fill_q;
    len_seen_d = len_seen_q;
    len_acc_d  = len_acc_q;
    left_d     = left_q;
    finish     = 1'b0;
    unique case (phase_q)
      PH_LENGTH: begin
        len_acc_d  = acc_next;
        len_seen_d = len_seen_q + 2'd1;
        if (len_seen_q == 2'd3) begin
          if (acc_next == 32'd0) begin
            finish = 1'b1;
          end else begin
            left_d  = acc_next;
            phase_d = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        left_d = left_next;
        if (left_next == 32'd0) begin
          finish = 1'b1;
        end
      end
      PH_SEARCH: begin
        if (done_q < record_limit_i) begin
          if (hit) begin
            window_d   = '0;
            fill_d     = '0;
            len_seen_d = '0;
            len_acc_d  = '0;
            phase_d    = PH_LENGTH;
          end else begin
            window_d = win_word[23:0];
            if (fill_q != 2'd3) begin
              fill_d = fill_q + 2'd1;
            end
          end
        end
      end
      default: begin
        phase_d = PH_SEARCH;
      end
    endcase
    if (finish) begin
      window_d   = '0;
      fill_d     = '0;
      len_seen_d = '0;
      len_acc_d  = '0;
      left_d     = '0;
      phase_d    = PH_SEARCH;
    end
  end

  assign done_d = finish ? done_q + 8'd1 : done_q;

  always_comb begin
    res_o.valid = 1'b0;
    res_o.burst = 1'b0;
    res_o.data  = byte_i;
    res_o.num   = done_q + 8'd1;
    res_o.last  = 1'b0;
    unique case (phase_q)
      PH_LENGTH: begin
        res_o.valid = 1'b1;
        res_o.last  = (len_seen_q == 2'd3) && (acc_next == 32'd0);
      end
      PH_PAYLOAD: begin
        res_o.valid = 1'b1;
        res_o.last  = (left_next == 32'd0);
      end
      PH_SEARCH: begin
        if ((done_q < record_limit_i) && hit) begin
          res_o.valid = 1'b1;
          res_o.burst = 1'b1;
          res_o.data  = marker_word_i[31:24];
        end
      end
      default: begin
        res_o.valid = 1'b0;
      end
    endcase
  end

  assign stat_o.phase        = phase_q;
  assign stat_o.len_seen     = len_seen_q;
  assign stat_o.payload_zero = (left_q == 32'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_SEARCH;
      window_q   <= '0;
      fill_q     <= '0;
      len_seen_q <= '0;
      len_acc_q  <= '0;
      left_q     <= '0;
      done_q     <= '0;
    end else if (step_i) begin
      phase_q    <= phase_d;
      window_q   <= window_d;
      fill_q     <= fill_d;
      len_seen_q <= len_seen_d;
      len_acc_q  <= len_acc_d;
      left_q     <= left_d;
      done_q     <= done_d;
    end
  end

endmodule

@@ rtl/msre_out_stage.sv @@
// Result register that also plays out the remaining marker bytes of a match.
module msre_out_stage import msre_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        load_i,
  input  res_t        res_i,
  input  logic [31:0] marker_word_i,
  input  logic        out_stall_i,
  output logic        free_o,
  output logic        burst_busy_o,
  output logic        out_valid_o,
  output logic [7:0]  out_byte_o,
  output logic [7:0]  record_number_o,
  output logic        record_end_o
);

  logic       valid_q, valid_d;
  logic [1:0] left_q, left_d;
  logic [7:0] byte_q, byte_d;
  logic [7:0] num_q, num_d;
  logic       end_q, end_d;
  logic       taken;
  logic [7:0] marker_byte;

  assign taken  = valid_q && !out_stall_i;
  assign free_o = (!valid_q || !out_stall_i) && (left_q == 2'd0);

  always_comb begin
    unique case (left_q)
      2'd3:    marker_byte = marker_word_i[23:16];
      2'd2:    marker_byte = marker_word_i[15:8];
      default: marker_byte = marker_word_i[7:0];
    endcase
  end

  always_comb begin
    valid_d = valid_q;
    left_d  = left_q;
    byte_d  = byte_q;
    num_d   = num_q;
    end_d   = end_q;
    if (taken && (left_q != 2'd0)) begin
      byte_d = marker_byte;
      end_d  = 1'b0;
      left_d = left_q - 2'd1;
    end else if (load_i) begin
      valid_d = 1'b1;
      byte_d  = res_i.data;
      num_d   = res_i.num;
      end_d   = res_i.last;
      left_d  = res_i.burst ? 2'd3 : 2'd0;
    end else if (taken) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      left_q  <= '0;
    end else begin
      valid_q <= valid_d;
      left_q  <= left_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    num_q  <= num_d;
    end_q  <= end_d;
  end

  assign burst_busy_o    = (left_q != 2'd0);
  assign out_valid_o     = valid_q;
  assign out_byte_o      = byte_q;
  assign record_number_o = num_q;
  assign record_end_o    = end_q;

endmodule
